### rtl/core/bscl_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear RGBA scaler package
// Shared types, field widths, operation codes and register indexes.
// ----------------------------------------------------------------------------
package bscl_pkg;

  localparam int MAX_SRC_WIDTH_DEF  = 256;
  localparam int MAX_SRC_HEIGHT_DEF = 256;
  localparam int OUT_WIDTH_DEF      = 100;
  localparam int OUT_HEIGHT_DEF     = 100;

  localparam int SZW      = 9;
  localparam int CW       = 8;
  localparam int CHW      = 8;
  localparam int PIXW     = 4 * CHW;
  localparam int NXW      = CW + SZW;
  localparam int CFG_IDXW = 1;

  localparam logic [SZW-1:0] SIZE_RESET = 9'd100;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  localparam logic [CFG_IDXW-1:0] CFG_SOURCE_WIDTH  = 1'd0;
  localparam logic [CFG_IDXW-1:0] CFG_SOURCE_HEIGHT = 1'd1;

  typedef struct packed {
    logic           operation;
    logic [CW-1:0]  col;
    logic [CW-1:0]  row;
    logic [CHW-1:0] in_red;
    logic [CHW-1:0] in_green;
    logic [CHW-1:0] in_blue;
    logic [CHW-1:0] in_alpha;
  } item_t;

  typedef struct packed {
    logic [CHW-1:0] out_red;
    logic [CHW-1:0] out_green;
    logic [CHW-1:0] out_blue;
    logic [CHW-1:0] out_alpha;
  } result_t;

  typedef struct packed {
    logic x0_odd;
    logic x1_odd;
    logic y0_odd;
    logic y1_odd;
  } corner_sel_t;

endpackage

### rtl/core/bilinear_rgba_scaler.sv
// ----------------------------------------------------------------------------
// Bilinear RGBA scaler
// Keeps a source image in four parity banks and resamples it to a fixed
// output grid with exact bilinear weights.
//
//   Channel  Ports                              Handshake
//   input    item (item_t)                      start, busy
//   output   result (result_t)                  done
//   config   cfg_index, cfg_data                cfg_we
//
// One word is accepted every clock while busy is low; an emit's result is on
// the result ports with done, and a load writes the store once its bank
// address, write enable and data are registered.
// The store is split by column and row parity into four single-port banks,
// so the four neighbours of a pixel are read in the same cycle.
// Reset is synchronous; busy is high for the cycle after reset, the size
// registers return to 100 and the image store stays undefined until written.
// The result side cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module bilinear_rgba_scaler
  import bscl_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
  parameter int OUT_WIDTH      = OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT     = OUT_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  item_t               item,
  output logic                done,
  output result_t             result,
  input  logic                cfg_we,
  input  logic [CFG_IDXW-1:0] cfg_index,
  input  logic [SZW-1:0]      cfg_data
);

  localparam int XW         = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
  localparam int YW         = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
  localparam int HALF_W     = (MAX_SRC_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int QXW        = NXW + 1 - $clog2(OUT_WIDTH);
  localparam int QYW        = NXW + 1 - $clog2(OUT_HEIGHT);
  localparam int RXW        = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
  localparam int RYW        = (OUT_HEIGHT > 1) ? $clog2(OUT_HEIGHT) : 1;
  localparam int WXW        = $clog2(OUT_WIDTH + 1);
  localparam int WYW        = $clog2(OUT_HEIGHT + 1);
  localparam int WW         = WXW + WYW;
  localparam int LAT        = 11;

  logic [SZW-1:0] src_width;
  logic [SZW-1:0] src_height;
  logic [SZW-1:0] w_eff;
  logic [SZW-1:0] h_eff;
  logic [SZW-1:0] wm1;
  logic [SZW-1:0] hm1;
  logic           accept;

  logic           a_emit;
  logic           a_load;
  item_t          a_item;
  logic [NXW-1:0] nx_a;
  logic [NXW-1:0] ny_a;

  logic [2:0]     d_emit;
  logic [2:0]     d_load;
  item_t          d_item [3];

  logic [QXW-1:0] xq;
  logic [QYW-1:0] yq;
  logic [RXW-1:0] xr;
  logic [RYW-1:0] yr;
  logic [XW-1:0]  x0;
  logic [XW-1:0]  x1;
  logic [YW-1:0]  y0;
  logic [YW-1:0]  y1;
  logic [XW-1:0]  lx;
  logic [YW-1:0]  ly;
  logic [WXW-1:0] fx;
  logic [WXW-1:0] gx;
  logic [WYW-1:0] fy;
  logic [WYW-1:0] gy;

  logic [3:0][AW-1:0]   addr_next;
  logic [3:0]           we_next;
  logic [3:0][AW-1:0]   e_addr;
  logic [3:0]           e_we;
  logic [PIXW-1:0]      e_wdata;
  logic                 e_emit;
  corner_sel_t          e_sel;
  logic [3:0][WW-1:0]   e_w;

  logic                 f_emit;
  corner_sel_t          f_sel;
  logic [3:0][WW-1:0]   f_w;
  logic [3:0][PIXW-1:0] rdata;
  logic [4:0]           bl_vld;

  always_comb begin
    if (src_width == '0) begin
      w_eff = SZW'(1);
    end else if (32'(src_width) > MAX_SRC_WIDTH) begin
      w_eff = SZW'(MAX_SRC_WIDTH);
    end else begin
      w_eff = src_width;
    end
    if (src_height == '0) begin
      h_eff = SZW'(1);
    end else if (32'(src_height) > MAX_SRC_HEIGHT) begin
      h_eff = SZW'(MAX_SRC_HEIGHT);
    end else begin
      h_eff = src_height;
    end
  end

  assign wm1    = w_eff - 1'b1;
  assign hm1    = h_eff - 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      src_width  <= SIZE_RESET;
      src_height <= SIZE_RESET;
    end else begin
      busy <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOURCE_WIDTH:  src_width  <= cfg_data;
          CFG_SOURCE_HEIGHT: src_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_emit <= 1'b0;
      a_load <= 1'b0;
      d_emit <= '0;
      d_load <= '0;
      e_we   <= '0;
      e_emit <= 1'b0;
      f_emit <= 1'b0;
      bl_vld <= '0;
    end else begin
      a_emit <= accept && item.operation == OP_EMIT
                && 32'(item.col) < OUT_WIDTH && 32'(item.row) < OUT_HEIGHT;
      a_load <= accept && item.operation == OP_LOAD
                && 32'(item.col) < MAX_SRC_WIDTH && 32'(item.row) < MAX_SRC_HEIGHT;
      d_emit <= {d_emit[1:0], a_emit};
      d_load <= {d_load[1:0], a_load};
      e_we   <= we_next;
      e_emit <= d_emit[2];
      f_emit <= e_emit;
      bl_vld <= {bl_vld[3:0], f_emit};
    end
  end

  always_ff @(posedge clk) begin
    a_item    <= item;
    nx_a      <= NXW'(item.col) * NXW'(w_eff);
    ny_a      <= NXW'(item.row) * NXW'(h_eff);
    d_item[0] <= a_item;
    d_item[1] <= d_item[0];
    d_item[2] <= d_item[1];
  end

  bscl_cdiv #(
    .NW (NXW),
    .D  (OUT_WIDTH)
  ) u_div_x (
    .clk (clk),
    .num (nx_a),
    .quo (xq),
    .rem (xr)
  );

  bscl_cdiv #(
    .NW (NXW),
    .D  (OUT_HEIGHT)
  ) u_div_y (
    .clk (clk),
    .num (ny_a),
    .quo (yq),
    .rem (yr)
  );

  always_comb begin
    x0 = (32'(xq) > 32'(wm1)) ? XW'(wm1) : XW'(xq);
    y0 = (32'(yq) > 32'(hm1)) ? YW'(hm1) : YW'(yq);
    x1 = (32'(x0) >= 32'(wm1)) ? x0 : x0 + 1'b1;
    y1 = (32'(y0) >= 32'(hm1)) ? y0 : y0 + 1'b1;
    lx = XW'(d_item[2].col);
    ly = YW'(d_item[2].row);
    fx = WXW'(xr);
    fy = WYW'(yr);
    gx = WXW'(OUT_WIDTH) - fx;
    gy = WYW'(OUT_HEIGHT) - fy;
  end

  always_comb begin
    logic [XW-1:0] xc;
    logic [YW-1:0] yc;
    for (int b = 0; b < 4; b++) begin
      if (d_emit[2]) begin
        xc = (x0[0] == b[0]) ? x0 : x1;
        yc = (y0[0] == b[1]) ? y0 : y1;
      end else begin
        xc = lx;
        yc = ly;
      end
      addr_next[b] = AW'(32'(yc >> 1) * HALF_W + 32'(xc >> 1));
      we_next[b]   = d_load[2] && lx[0] == b[0] && ly[0] == b[1];
    end
  end

  always_ff @(posedge clk) begin
    e_addr       <= addr_next;
    e_wdata      <= {d_item[2].in_alpha, d_item[2].in_blue, d_item[2].in_green,
                     d_item[2].in_red};
    e_sel.x0_odd <= x0[0];
    e_sel.x1_odd <= x1[0];
    e_sel.y0_odd <= y0[0];
    e_sel.y1_odd <= y1[0];
    e_w[0]       <= WW'(gx) * WW'(gy);
    e_w[1]       <= WW'(fx) * WW'(gy);
    e_w[2]       <= WW'(gx) * WW'(fy);
    e_w[3]       <= WW'(fx) * WW'(fy);
    f_sel        <= e_sel;
    f_w          <= e_w;
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bscl_ram #(
      .WIDTH (PIXW),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (e_we[b]),
      .addr  (e_addr[b]),
      .wdata (e_wdata),
      .rdata (rdata[b])
    );
  end

  bscl_blend #(
    .WW         (WW),
    .OUT_WIDTH  (OUT_WIDTH),
    .OUT_HEIGHT (OUT_HEIGHT)
  ) u_blend (
    .clk       (clk),
    .bank_data (rdata),
    .sel       (f_sel),
    .weight    (f_w),
    .result    (result)
  );

  assign done = bl_vld[4];

  assert property (@(posedge clk) disable iff (rst) $onehot0(e_we))
    else $error("More than one image bank written in one cycle.");

  assert property (@(posedge clk) disable iff (rst)
    d_emit[2] |-> (32'(xr) < OUT_WIDTH && 32'(yr) < OUT_HEIGHT))
    else $error("Position remainder out of range.");

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept && item.operation == OP_EMIT, LAT))
    else $error("Result word without a matching emit word.");

  assert property (@(posedge clk) disable iff (rst)
    e_emit |-> (32'(e_w[0]) + 32'(e_w[1]) + 32'(e_w[2]) + 32'(e_w[3])
                == OUT_WIDTH * OUT_HEIGHT))
    else $error("Corner weights do not add up to the full weight.");

endmodule

### rtl/core/bscl_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle: a write, or a read whose data is registered.
// ----------------------------------------------------------------------------
module bscl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/core/bscl_cdiv.sv
// ----------------------------------------------------------------------------
// Constant divider
// Three-stage floor division by a constant: reciprocal multiply, remainder,
// and one correction step. Gives quotient and remainder.
// ----------------------------------------------------------------------------
module bscl_cdiv #(
  parameter int NW = 17,
  parameter int D  = 100
) (
  input  logic                                clk,
  input  logic [NW-1:0]                       num,
  output logic [NW-$clog2(D):0]               quo,
  output logic [((D > 1) ? $clog2(D) : 1)-1:0] rem
);

  localparam int CLD = $clog2(D);
  localparam int S   = NW + CLD;
  localparam int QW  = NW + 1 - CLD;
  localparam int RW  = (D > 1) ? CLD : 1;
  localparam int PW  = 2 * NW + 1;
  localparam logic [S:0]  ONE_S = (S + 1)'(1) << S;
  localparam logic [S:0]  MFULL = ONE_S / (S + 1)'(D);
  localparam logic [NW:0] M     = MFULL[NW:0];

  logic [NW-1:0] n1;
  logic [PW-1:0] prod1;
  logic [QW-1:0] q_est;
  logic [NW-1:0] diff;
  logic [QW-1:0] q2;
  logic [CLD:0]  r2;

  assign q_est = prod1[PW-1:S];
  assign diff  = n1 - NW'(32'(q_est) * D);

  always_ff @(posedge clk) begin
    n1    <= num;
    prod1 <= PW'(num) * PW'(M);
    q2    <= q_est;
    r2    <= diff[CLD:0];
    if (32'(r2) >= D) begin
      quo <= q2 + 1'b1;
      rem <= RW'(32'(r2) - D);
    end else begin
      quo <= q2;
      rem <= RW'(r2);
    end
  end

endmodule

### rtl/core/bscl_blend.sv
// ----------------------------------------------------------------------------
// Bilinear blend
// Routes the four bank words to the corners, weights each channel, sums the
// corners and divides by the total weight.
// ----------------------------------------------------------------------------
module bscl_blend
  import bscl_pkg::*;
#(
  parameter int WW         = 14,
  parameter int OUT_WIDTH  = OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT = OUT_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic [3:0][PIXW-1:0]      bank_data,
  input  corner_sel_t               sel,
  input  logic [3:0][WW-1:0]        weight,
  output result_t                   result
);

  localparam int DEN  = OUT_WIDTH * OUT_HEIGHT;
  localparam int SUMW = $clog2(255 * DEN + 1);
  localparam int PRW  = CHW + WW;
  localparam int QW   = SUMW + 1 - $clog2(DEN);
  localparam int RW   = (DEN > 1) ? $clog2(DEN) : 1;

  logic [3:0][PIXW-1:0]      pix;
  logic [3:0][3:0][PRW-1:0]  prod;
  logic [3:0][SUMW-1:0]      sum;
  logic [3:0][QW-1:0]        quo;
  logic [3:0][RW-1:0]        rem;

  assign pix[0] = bank_data[{sel.y0_odd, sel.x0_odd}];
  assign pix[1] = bank_data[{sel.y0_odd, sel.x1_odd}];
  assign pix[2] = bank_data[{sel.y1_odd, sel.x0_odd}];
  assign pix[3] = bank_data[{sel.y1_odd, sel.x1_odd}];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        prod[c][k] <= PRW'(pix[k][CHW*c +: CHW]) * PRW'(weight[k]);
      end
      sum[c] <= SUMW'(prod[c][0]) + SUMW'(prod[c][1]) + SUMW'(prod[c][2])
              + SUMW'(prod[c][3]);
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_div
    bscl_cdiv #(
      .NW (SUMW),
      .D  (DEN)
    ) u_div (
      .clk (clk),
      .num (sum[c]),
      .quo (quo[c]),
      .rem (rem[c])
    );
  end

  assign result.out_red   = quo[0][CHW-1:0];
  assign result.out_green = quo[1][CHW-1:0];
  assign result.out_blue  = quo[2][CHW-1:0];
  assign result.out_alpha = quo[3][CHW-1:0];

endmodule

### tb/bscl_checker.sv
// ----------------------------------------------------------------------------
// Bilinear RGBA scaler checker
// Watches the input, result and configuration ports of the scaler. It keeps
// its own copy of the image store and size registers, works out the pixel
// that each accepted in-range emit word must give, and compares every result word
// with the oldest expected pixel, channel by channel.
// ----------------------------------------------------------------------------
module bscl_checker
  import bscl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  item_t               item,
  input  logic                done,
  input  result_t             result,
  input  logic                cfg_we,
  input  logic [CFG_IDXW-1:0] cfg_index,
  input  logic [SZW-1:0]      cfg_data,
  output int                  fails,
  output int                  pending
);

  logic [SZW-1:0]  src_width  = SIZE_RESET;
  logic [SZW-1:0]  src_height = SIZE_RESET;
  logic [PIXW-1:0] image [0:MAX_SRC_WIDTH_DEF*MAX_SRC_HEIGHT_DEF-1];
  result_t         expected_pixels [$];
  int              miss_count = 0;
  string           channel_names [4] = '{"alpha", "blue", "green", "red"};

  function automatic int unsigned clamp_size(logic [SZW-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic result_t scale_pixel(logic [CW-1:0] c, logic [CW-1:0] r);
    int unsigned     w, h, nx, ny, x0, y0, x1, y1, fx, fy, gx, gy, acc;
    logic [PIXW-1:0] p00, p01, p10, p11, mix;
    w  = clamp_size(src_width, MAX_SRC_WIDTH_DEF);
    h  = clamp_size(src_height, MAX_SRC_HEIGHT_DEF);
    nx = c * w;
    ny = r * h;
    x0 = nx / OUT_WIDTH_DEF;
    y0 = ny / OUT_HEIGHT_DEF;
    fx = nx % OUT_WIDTH_DEF;
    fy = ny % OUT_HEIGHT_DEF;
    if (x0 > w - 1) x0 = w - 1;
    if (y0 > h - 1) y0 = h - 1;
    x1  = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
    y1  = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
    p00 = image[y0 * MAX_SRC_WIDTH_DEF + x0];
    p01 = image[y0 * MAX_SRC_WIDTH_DEF + x1];
    p10 = image[y1 * MAX_SRC_WIDTH_DEF + x0];
    p11 = image[y1 * MAX_SRC_WIDTH_DEF + x1];
    gx  = OUT_WIDTH_DEF - fx;
    gy  = OUT_HEIGHT_DEF - fy;
    for (int k = 0; k < 4; k++) begin
      acc = p00[8*k +: 8] * gx * gy + p01[8*k +: 8] * fx * gy
          + p10[8*k +: 8] * gx * fy + p11[8*k +: 8] * fx * fy;
      mix[8*k +: 8] = 8'(acc / (OUT_WIDTH_DEF * OUT_HEIGHT_DEF));
    end
    return {mix[7:0], mix[15:8], mix[23:16], mix[31:24]};
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      src_width  = SIZE_RESET;
      src_height = SIZE_RESET;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SOURCE_WIDTH) src_width = cfg_data;
        else src_height = cfg_data;
      end
      if (done) begin
        if (expected_pixels.size() == 0) begin
          miss_count++;
          $display("%0t: result word, expected none, actual %h", $time, result);
        end else begin
          want = expected_pixels.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (want[8*k +: 8] !== result[8*k +: 8]) begin
              miss_count++;
              $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                       channel_names[k], want[8*k +: 8], result[8*k +: 8]);
            end
          end
        end
      end
      if (start && !busy) begin
        if (item.operation == OP_LOAD) begin
          image[{item.row, item.col}] = {item.in_alpha, item.in_blue, item.in_green,
                                         item.in_red};
        end else if (item.col < OUT_WIDTH_DEF && item.row < OUT_HEIGHT_DEF) begin
          expected_pixels.push_back(scale_pixel(item.col, item.row));
        end
      end
    end
    fails   <= miss_count;
    pending <= expected_pixels.size();
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Bilinear RGBA scaler testbench
// Drives load and emit words into the scaler under several source sizes,
// including the zero, saturating and pass-through sizes. Before each emit
// the four source pixels it reads are loaded if they were never written.
// A checker beside the scaler predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
  import bscl_pkg::*;

  localparam int DRAIN_CYCLES = 16;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  item_t               item      = '0;
  logic                cfg_we    = 1'b0;
  logic [CFG_IDXW-1:0] cfg_index = CFG_SOURCE_WIDTH;
  logic [SZW-1:0]      cfg_data  = '0;
  logic                busy;
  logic                done;
  result_t             result;
  int                  fails;
  int                  pending;

  logic [SZW-1:0] cur_width  = SIZE_RESET;
  logic [SZW-1:0] cur_height = SIZE_RESET;
  bit             loaded [0:MAX_SRC_WIDTH_DEF*MAX_SRC_HEIGHT_DEF-1];
  int             idle_pct   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bilinear_rgba_scaler u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bscl_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  task automatic send_word(item_t word);
    start <= 1'b1;
    item  <= word;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_pixel(int unsigned x, int unsigned y, logic [PIXW-1:0] rgba);
    item_t word;
    word.operation = OP_LOAD;
    word.col       = 8'(x);
    word.row       = 8'(y);
    {word.in_alpha, word.in_blue, word.in_green, word.in_red} = rgba;
    loaded[y * MAX_SRC_WIDTH_DEF + x] = 1'b1;
    send_word(word);
  endtask

  task automatic fill_pixel(int unsigned x, int unsigned y);
    if (!loaded[y * MAX_SRC_WIDTH_DEF + x]) load_pixel(x, y, $urandom());
  endtask

  // The four neighbours an emit reads are loaded first, so no unwritten
  // pixel is ever read back.
  task automatic emit_pixel(logic [CW-1:0] c, logic [CW-1:0] r);
    int unsigned w, h, x0, y0, x1, y1;
    item_t       word;
    w  = (cur_width == '0) ? 1 :
         (cur_width > MAX_SRC_WIDTH_DEF) ? MAX_SRC_WIDTH_DEF : cur_width;
    h  = (cur_height == '0) ? 1 :
         (cur_height > MAX_SRC_HEIGHT_DEF) ? MAX_SRC_HEIGHT_DEF : cur_height;
    x0 = c * w / OUT_WIDTH_DEF;
    y0 = r * h / OUT_HEIGHT_DEF;
    if (x0 > w - 1) x0 = w - 1;
    if (y0 > h - 1) y0 = h - 1;
    x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
    y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
    if (c < OUT_WIDTH_DEF && r < OUT_HEIGHT_DEF) begin
      fill_pixel(x0, y0);
      fill_pixel(x1, y0);
      fill_pixel(x0, y1);
      fill_pixel(x1, y1);
    end
    word.operation = OP_EMIT;
    word.col       = c;
    word.row       = r;
    {word.in_alpha, word.in_blue, word.in_green, word.in_red} = $urandom();
    send_word(word);
  endtask

  task automatic set_sizes(logic [SZW-1:0] w, logic [SZW-1:0] h);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SOURCE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_SOURCE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_width  = w;
    cur_height = h;
  endtask

  task automatic random_phase(int count);
    int             pick;
    logic [CW-1:0]  c, r;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      c    = 8'($urandom_range(OUT_WIDTH_DEF - 1));
      r    = 8'($urandom_range(OUT_HEIGHT_DEF - 1));
      if (pick < 12) begin
        load_pixel($urandom_range(255), $urandom_range(255), $urandom());
      end else if (pick < 24) begin
        if ($urandom_range(1) == 1) c = 8'($urandom_range(255, OUT_WIDTH_DEF));
        else r = 8'($urandom_range(255, OUT_HEIGHT_DEF));
        emit_pixel(c, r);
      end else begin
        if (pick < 34) c = ($urandom_range(1) == 1) ? 8'(OUT_WIDTH_DEF - 1) : 8'd0;
        if (pick >= 29 && pick < 39) begin
          r = ($urandom_range(1) == 1) ? 8'(OUT_HEIGHT_DEF - 1) : 8'd0;
        end
        emit_pixel(c, r);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    load_pixel(0, 0, 32'h0000_0000);
    load_pixel(255, 255, 32'hFFFF_FFFF);
    load_pixel(1, 0, 32'hFF00_FF00);
    load_pixel(0, 1, 32'h00FF_00FF);
    load_pixel(1, 1, 32'hFFFF_FFFF);
    emit_pixel(8'd0, 8'd0);
    emit_pixel(8'd99, 8'd99);
    emit_pixel(8'd99, 8'd0);
    emit_pixel(8'd0, 8'd99);
    emit_pixel(8'd50, 8'd50);
    emit_pixel(8'd100, 8'd0);
    emit_pixel(8'd0, 8'd100);
    emit_pixel(8'd255, 8'd255);
    emit_pixel(8'd128, 8'd7);
    set_sizes(9'd0, 9'd0);
    emit_pixel(8'd0, 8'd0);
    emit_pixel(8'd99, 8'd99);
    set_sizes(9'd511, 9'd511);
    emit_pixel(8'd99, 8'd99);
    emit_pixel(8'd0, 8'd0);

    idle_pct = 30;
    random_phase(12);
    set_sizes(9'd1, 9'd256);
    random_phase(10);
    set_sizes(9'd256, 9'd1);
    random_phase(10);
    idle_pct = 10;
    set_sizes(9'd256, 9'd256);
    random_phase(16);
    idle_pct = 40;
    set_sizes(9'd37, 9'd150);
    random_phase(16);
    idle_pct = 20;
    set_sizes(9'd300, 9'd7);
    random_phase(12);
    set_sizes(9'($urandom_range(256, 1)), 9'($urandom_range(256, 1)));
    random_phase(18);
    idle_pct = 0;
    set_sizes(9'd100, 9'd100);
    random_phase(22);

    drain();
    if (fails == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
rtl/core/bscl_pkg.sv
rtl/core/bscl_ram.sv
rtl/core/bscl_cdiv.sv
rtl/core/bscl_blend.sv
rtl/core/bilinear_rgba_scaler.sv
tb/bscl_checker.sv
tb/tb.sv
